>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PPS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a trigger is followed by a condition on the next clock edge.
`define PPS_ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/core/pps_pkg.sv
package pps_pkg;

    localparam int unsigned SLOTS_DEFAULT = 16;

    // Fixed widths of the item fields
    localparam int unsigned TIME_W = 16;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned ID_W   = 8;
    localparam int unsigned SLOT_W = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Slot write broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } pps_load_t;

    // Best candidate handed down the cell chain
    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [ID_W-1:0]   id;
        logic              last;
    } pps_cand_t;

endpackage

>>> rtl/core/pps_if.sv
interface pps_cmd_if;
    import pps_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   process_id;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_length;
    logic [PRIO_W-1:0] priority_level;

    modport source (
        output valid, kind, slot, process_id, arrival_time, burst_length, priority_level,
        input  ready
    );

    modport sink (
        input  valid, kind, slot, process_id, arrival_time, burst_length, priority_level,
        output ready
    );
endinterface

interface pps_rpt_if;
    import pps_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] current_time;
    logic              busy_res;
    logic [ID_W-1:0]   running_id;
    logic              segment_start;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;

    modport source (
        output valid, current_time, busy_res, running_id, segment_start, finished,
               finish_time, turnaround, waiting, all_done,
        input  ready
    );

    modport sink (
        input  valid, current_time, busy_res, running_id, segment_start, finished,
               finish_time, turnaround, waiting, all_done,
        output ready
    );
endinterface

>>> rtl/core/pps_cell.sv
module pps_cell #(
    parameter int unsigned SLOT_INDEX = 0,
    parameter int unsigned IDX_W      = 4,
    parameter int unsigned CNT_W      = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pps_pkg::TIME_W-1:0] now,
    input  pps_pkg::pps_load_t        load,
    input  logic                      commit,
    input  pps_pkg::pps_cand_t        cand_in,
    input  logic [IDX_W-1:0]          idx_in,
    input  logic [CNT_W-1:0]          pend_in,
    output pps_pkg::pps_cand_t        cand_out,
    output logic [IDX_W-1:0]          idx_out,
    output logic [CNT_W-1:0]          pend_out
);
    import pps_pkg::*;

    // Cells past the reach of the slot field are never written
    localparam logic REACHABLE = (SLOT_INDEX < (2 ** SLOT_W));

    logic              valid_reg;
    logic              done_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] arrival_reg;
    logic [TIME_W-1:0] burst_reg;
    logic [TIME_W-1:0] remaining_reg;
    logic [PRIO_W-1:0] prio_reg;

    pps_cand_t         cand_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  pend_reg;

    logic              hit;
    logic              pending;
    logic              eligible;
    logic              better;
    logic              last;

    assign hit      = load.en && REACHABLE && (load.slot == SLOT_W'(SLOT_INDEX));
    assign pending  = valid_reg && !done_reg;
    assign eligible = pending && (arrival_reg <= now);
    assign last     = (remaining_reg[TIME_W-1:1] == '0);
    // Strictly better only: a full tie keeps the lower slot from upstream
    assign better   = eligible && (!cand_in.found || (prio_reg < cand_in.prio) ||
                      ((prio_reg == cand_in.prio) && (arrival_reg < cand_in.arrival)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            cand_reg  <= '0;
            idx_reg   <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            if (hit)
            begin
                valid_reg <= 1'b1;
                done_reg  <= 1'b0;
            end
            else if (commit && last)
            begin
                done_reg <= 1'b1;
            end

            if (better)
            begin
                cand_reg <= '{found: 1'b1, prio: prio_reg, arrival: arrival_reg,
                              burst: burst_reg, id: id_reg, last: last};
                idx_reg  <= IDX_W'(SLOT_INDEX);
            end
            else
            begin
                cand_reg <= cand_in;
                idx_reg  <= idx_in;
            end
            pend_reg <= pend_in + CNT_W'(pending);
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            id_reg        <= load.id;
            arrival_reg   <= load.arrival;
            burst_reg     <= load.burst;
            remaining_reg <= load.burst;
            prio_reg      <= load.prio;
        end
        else if (commit && !last)
        begin
            remaining_reg <= remaining_reg - TIME_W'(1);
        end
    end

    assign cand_out = cand_reg;
    assign idx_out  = idx_reg;
    assign pend_out = pend_reg;

endmodule

>>> rtl/core/preemptive_priority_scheduler.sv
// Channel | Role   | Handshake   | Item
// cmd     | sink   | valid/ready | load a slot (kind 0) or advance one time unit (kind 1)
// rpt     | source | valid/ready | one report per time unit: running process, segment, stats
//
// Load: written into its cell at the accepting edge, no report.
// Tick: the search token walks the cell chain, one cell a cycle, then ST_CALC and ST_POST.
// Reset clears the time counter, every slot's valid and finished flags, and the last choice.
// cmd is ready only between items; a tick whose report cannot enter the output
// register holds in its final step until rpt is taken, with no state committed.
module preemptive_priority_scheduler #(
    parameter int unsigned SLOTS = pps_pkg::SLOTS_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    pps_cmd_if.sink   cmd,
    pps_rpt_if.source rpt
);
    import pps_pkg::*;

    localparam int unsigned IDX_W    = $clog2(SLOTS);
    localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
    localparam int unsigned CHOICE_W = $clog2(SLOTS + 2);
    localparam logic [CHOICE_W-1:0] MARK_IDLE = CHOICE_W'(SLOTS);
    localparam logic [CHOICE_W-1:0] MARK_NONE = CHOICE_W'(SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_CALC,
        ST_POST
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    sweep_cnt_reg;
    logic [TIME_W-1:0]   clock_count_reg;
    logic [TIME_W-1:0]   fin_reg;
    logic [TIME_W-1:0]   tat_reg;
    pps_cand_t           best_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [CNT_W-1:0]    pend_reg;
    logic [CHOICE_W-1:0] last_choice_reg;

    logic                rpt_valid_reg;
    logic [TIME_W-1:0]   current_time_reg;
    logic                busy_reg;
    logic [ID_W-1:0]     running_id_reg;
    logic                segment_reg;
    logic                finished_reg;
    logic [TIME_W-1:0]   finish_time_reg;
    logic [TIME_W-1:0]   turnaround_reg;
    logic [TIME_W-1:0]   waiting_reg;
    logic                all_done_reg;

    logic                cmd_take;
    logic                out_free;
    logic                post;
    logic                commit;
    logic                fin_now;
    logic [CHOICE_W-1:0] choice;
    logic [TIME_W-1:0]   wait_time;
    logic [SLOTS-1:0]    commit_hit;
    pps_load_t           load;

    pps_cand_t           cand_chain [SLOTS+1];
    logic [IDX_W-1:0]    idx_chain  [SLOTS+1];
    logic [CNT_W-1:0]    pend_chain [SLOTS+1];

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_take  = cmd.valid && cmd.ready;
    assign out_free  = !rpt_valid_reg || rpt.ready;
    assign post      = (state_reg == ST_POST) && out_free;
    assign commit    = post && best_reg.found;
    assign fin_now   = best_reg.found && best_reg.last;
    assign choice    = best_reg.found ? CHOICE_W'(best_idx_reg) : MARK_IDLE;
    // Waiting time clamps at zero when the burst outlasts the turnaround
    assign wait_time = (tat_reg >= best_reg.burst) ? (tat_reg - best_reg.burst) : '0;

    // Broadcast a slot write; only the addressed cell takes it
    assign load = '{en: cmd_take && (cmd.kind == KIND_LOAD), slot: cmd.slot,
                    id: cmd.process_id, arrival: cmd.arrival_time,
                    burst: cmd.burst_length, prio: cmd.priority_level};

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            commit_hit[i] = commit && (best_idx_reg == IDX_W'(i));
        end
    end

    // Chain head: empty candidate, nothing pending counted yet
    assign cand_chain[0] = '0;
    assign idx_chain[0]  = '0;
    assign pend_chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        pps_cell #(
            .SLOT_INDEX (g),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .now      (clock_count_reg),
            .load     (load),
            .commit   (commit_hit[g]),
            .cand_in  (cand_chain[g]),
            .idx_in   (idx_chain[g]),
            .pend_in  (pend_chain[g]),
            .cand_out (cand_chain[g+1]),
            .idx_out  (idx_chain[g+1]),
            .pend_out (pend_chain[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sweep_cnt_reg    <= '0;
            clock_count_reg  <= '0;
            fin_reg          <= '0;
            tat_reg          <= '0;
            best_reg         <= '0;
            best_idx_reg     <= '0;
            pend_reg         <= '0;
            last_choice_reg  <= MARK_NONE;
            rpt_valid_reg    <= 1'b0;
            current_time_reg <= '0;
            busy_reg         <= 1'b0;
            running_id_reg   <= '0;
            segment_reg      <= 1'b0;
            finished_reg     <= 1'b0;
            finish_time_reg  <= '0;
            turnaround_reg   <= '0;
            waiting_reg      <= '0;
            all_done_reg     <= 1'b0;
        end
        else
        begin
            // Raise the report when a tick posts; drop it once taken
            if (post)
            begin
                rpt_valid_reg <= 1'b1;
            end
            else if (rpt.ready)
            begin
                rpt_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_take && (cmd.kind == KIND_TICK))
                    begin
                        // Completion time if the pick finishes now, saturating
                        fin_reg       <= (clock_count_reg == TIME_MAX) ?
                                         clock_count_reg : clock_count_reg + TIME_W'(1);
                        sweep_cnt_reg <= IDX_W'(SLOTS - 1);
                        state_reg     <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    // Let the token walk the whole chain with the table held still
                    if (sweep_cnt_reg == '0)
                    begin
                        state_reg <= ST_CALC;
                    end
                    else
                    begin
                        sweep_cnt_reg <= sweep_cnt_reg - IDX_W'(1);
                    end
                end
                ST_CALC:
                begin
                    best_reg     <= cand_chain[SLOTS];
                    best_idx_reg <= idx_chain[SLOTS];
                    pend_reg     <= pend_chain[SLOTS];
                    tat_reg      <= fin_reg - cand_chain[SLOTS].arrival;
                    state_reg    <= ST_POST;
                end
                ST_POST:
                begin
                    if (out_free)
                    begin
                        current_time_reg <= clock_count_reg;
                        busy_reg         <= best_reg.found;
                        running_id_reg   <= best_reg.found ? best_reg.id : '0;
                        segment_reg      <= (choice != last_choice_reg);
                        finished_reg     <= fin_now;
                        finish_time_reg  <= fin_now ? fin_reg : '0;
                        turnaround_reg   <= fin_now ? tat_reg : '0;
                        waiting_reg      <= fin_now ? wait_time : '0;
                        // Pending count was taken before this tick's completion
                        all_done_reg     <= (pend_reg == '0) ||
                                            ((pend_reg == CNT_W'(1)) && fin_now);
                        last_choice_reg  <= choice;
                        if (clock_count_reg != TIME_MAX)
                        begin
                            clock_count_reg <= clock_count_reg + TIME_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rpt.valid         = rpt_valid_reg;
    assign rpt.current_time  = current_time_reg;
    assign rpt.busy_res      = busy_reg;
    assign rpt.running_id    = running_id_reg;
    assign rpt.segment_start = segment_reg;
    assign rpt.finished      = finished_reg;
    assign rpt.finish_time   = finish_time_reg;
    assign rpt.turnaround    = turnaround_reg;
    assign rpt.waiting       = waiting_reg;
    assign rpt.all_done      = all_done_reg;

`include "assert_macros.svh"

    // At most one cell is updated per time unit
    `PPS_ASSERT(a_commit_onehot, $onehot0(commit_hit), "more than one cell committed")
    // Finishing a tick always leaves a report behind and reopens the input
    `PPS_ASSERT_NEXT(a_post_report, post, rpt_valid_reg && (state_reg == ST_IDLE),
                     "tick ended without a report")
    // Time only moves when a tick is reported
    `PPS_ASSERT_NEXT(a_time_hold, !post, $stable(clock_count_reg), "time counter moved outside a tick")

endmodule

>>> tb/pps_schedule_monitor.sv
module pps_schedule_monitor
    import pps_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    pps_cmd_if          cmd,
    pps_rpt_if          rpt,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Choice markers beside the slot numbers
    localparam int PICK_IDLE = SLOTS;
    localparam int PICK_NONE = SLOTS + 1;

    typedef struct packed {
        logic [TIME_W-1:0] at_time;
        logic              busy;
        logic [ID_W-1:0]   pid;
        logic              seg;
        logic              done_now;
        logic [TIME_W-1:0] fin_time;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wait_time;
        logic              all_fin;
    } report_t;

    logic [TIME_W-1:0] sched_time;
    logic [SLOTS-1:0]  slot_live;
    logic [SLOTS-1:0]  slot_done;
    logic [ID_W-1:0]   slot_pid  [SLOTS];
    logic [TIME_W-1:0] slot_arr  [SLOTS];
    logic [TIME_W-1:0] slot_len  [SLOTS];
    logic [TIME_W-1:0] slot_left [SLOTS];
    logic [PRIO_W-1:0] slot_prio [SLOTS];
    int                prev_pick;

    report_t pending_reports [$];
    report_t want;
    int unsigned err_count = 0;

    // Pick the slot for one time unit, run it and build the report
    function automatic report_t schedule_tick();
        report_t           r;
        int                best;
        int                pick;
        int                i;
        logic [TIME_W-1:0] fin_t;
        logic [TIME_W-1:0] span;
        r = '0;
        best = -1;
        for (i = 0; i < SLOTS; i++)
        begin
            if (slot_live[i] && !slot_done[i] && slot_arr[i] <= sched_time)
            begin
                if (best < 0 || slot_prio[i] < slot_prio[best]
                    || (slot_prio[i] == slot_prio[best] && slot_arr[i] < slot_arr[best]))
                    best = i;
            end
        end
        r.at_time = sched_time;
        pick = (best < 0) ? PICK_IDLE : best;
        r.seg = (pick != prev_pick);
        prev_pick = pick;
        if (best >= 0)
        begin
            r.busy = 1'b1;
            r.pid = slot_pid[best];
            if (slot_left[best] <= 1)
            begin
                fin_t = (sched_time != TIME_MAX) ? sched_time + 1'b1 : TIME_MAX;
                span = fin_t - slot_arr[best];
                slot_left[best] = '0;
                slot_done[best] = 1'b1;
                r.done_now = 1'b1;
                r.fin_time = fin_t;
                r.tat = span;
                r.wait_time = (span >= slot_len[best]) ? span - slot_len[best] : '0;
            end
            else
                slot_left[best] = slot_left[best] - 1'b1;
        end
        r.all_fin = ((slot_live & ~slot_done) == '0);
        if (sched_time != TIME_MAX)
            sched_time = sched_time + 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_time = '0;
            slot_live = '0;
            slot_done = '0;
            prev_pick = PICK_NONE;
            pending_reports.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                if (cmd.kind == KIND_LOAD)
                begin
                    if (cmd.slot < SLOTS)
                    begin
                        slot_live[cmd.slot] = 1'b1;
                        slot_done[cmd.slot] = 1'b0;
                        slot_pid[cmd.slot] = cmd.process_id;
                        slot_arr[cmd.slot] = cmd.arrival_time;
                        slot_len[cmd.slot] = cmd.burst_length;
                        slot_left[cmd.slot] = cmd.burst_length;
                        slot_prio[cmd.slot] = cmd.priority_level;
                    end
                end
                else
                    pending_reports.push_back(schedule_tick());
            end
            if (rpt.valid && rpt.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: unexpected report, expected none, actual time %0d",
                             $time, rpt.current_time);
                    err_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("current_time", 32'(want.at_time), 32'(rpt.current_time));
                    check_field("busy_res", 32'(want.busy), 32'(rpt.busy_res));
                    check_field("running_id", 32'(want.pid), 32'(rpt.running_id));
                    check_field("segment_start", 32'(want.seg), 32'(rpt.segment_start));
                    check_field("finished", 32'(want.done_now), 32'(rpt.finished));
                    check_field("finish_time", 32'(want.fin_time), 32'(rpt.finish_time));
                    check_field("turnaround", 32'(want.tat), 32'(rpt.turnaround));
                    check_field("waiting", 32'(want.wait_time), 32'(rpt.waiting));
                    check_field("all_done", 32'(want.all_fin), 32'(rpt.all_done));
                end
            end
            mismatches <= err_count;
            outstanding <= pending_reports.size();
        end
    end

endmodule

>>> tb/tb_preemptive_priority_scheduler.sv
module tb_preemptive_priority_scheduler
    import pps_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS        = SLOTS_DEFAULT;
    localparam int          RANDOM_ITEMS = 990;
    // Long receiver hold-off, so a report sits in the output register and the
    // next tick backs up into cmd
    localparam int          CHOKE_AT     = 350;
    localparam int          CHOKE_ITEMS  = 40;
    localparam int          CHOKE_CYCLES = 300;
    // Sender pause until every report is back
    localparam int          DRAIN_AT     = 700;
    // Some 1050 items, plus gaps and hold-offs
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        quiet = 1'b0;
    logic        choke_req = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned mismatches;
    int unsigned outstanding;

    // Time the block should be at, counted from the ticks handed over
    logic [TIME_W-1:0] issued_time = '0;

    pps_cmd_if cmd ();
    pps_rpt_if rpt ();

    preemptive_priority_scheduler #(
        .SLOTS (SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rpt   (rpt)
    );

    pps_schedule_monitor #(
        .SLOTS (SLOTS)
    ) sched_mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rpt         (rpt),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one item and hold it until the block takes it. Insert a random
    // gap first unless the run is in its quiet tail.
    task automatic drive_item(input logic kind_v, input logic [SLOT_W-1:0] slot_v,
                              input logic [ID_W-1:0] id_v, input logic [TIME_W-1:0] arr_v,
                              input logic [TIME_W-1:0] burst_v,
                              input logic [PRIO_W-1:0] prio_v);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.kind <= kind_v;
        cmd.slot <= slot_v;
        cmd.process_id <= id_v;
        cmd.arrival_time <= arr_v;
        cmd.burst_length <= burst_v;
        cmd.priority_level <= prio_v;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (kind_v == KIND_TICK && issued_time != TIME_MAX)
            issued_time = issued_time + 1'b1;
    endtask

    task automatic load_slot(input logic [SLOT_W-1:0] slot_v, input logic [ID_W-1:0] id_v,
                             input logic [TIME_W-1:0] arr_v, input logic [TIME_W-1:0] burst_v,
                             input logic [PRIO_W-1:0] prio_v);
        drive_item(KIND_LOAD, slot_v, id_v, arr_v, burst_v, prio_v);
    endtask

    // Load fields ride along with random content; the block must ignore them
    task automatic advance_time();
        drive_item(KIND_TICK, SLOT_W'($urandom), ID_W'($urandom), TIME_W'($urandom),
                   TIME_W'($urandom), PRIO_W'($urandom));
    endtask

    // Receiver: random ready, one long hold-off on request, steady in the tail
    initial
    begin
        rpt.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (choke_req)
            begin
                rpt.ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
                choke_req = 1'b0;
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                rpt.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                rpt.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int                n;
        int                roll;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;

        cmd.valid <= 1'b0;
        cmd.kind <= KIND_LOAD;
        cmd.slot <= '0;
        cmd.process_id <= '0;
        cmd.arrival_time <= '0;
        cmd.burst_length <= '0;
        cmd.priority_level <= '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Ticks on an empty table: idle, segment on the first one,
        // everything counts as done.
        advance_time();
        advance_time();
        // Zero burst at the weakest priority, and a slot with every field at its
        // extreme that never becomes eligible
        load_slot(4'd0, 8'hFF, 16'd0, 16'd0, 8'hFF);
        load_slot(4'd15, 8'h00, 16'hFFFF, 16'hFFFF, 8'h00);
        // Equal priority: earlier arrival wins, then the lower slot
        load_slot(4'd1, 8'h11, 16'd2, 16'd2, 8'd3);
        load_slot(4'd2, 8'h22, 16'd2, 16'd2, 8'd3);
        load_slot(4'd3, 8'h33, 16'd1, 16'd1, 8'd3);
        repeat (6) advance_time();
        // Start a weak process, then preempt it with one that arrived long ago
        load_slot(4'd5, 8'hA5, 16'd8, 16'd4, 8'd7);
        advance_time();
        advance_time();
        load_slot(4'd4, 8'h5A, 16'd0, 16'd2, 8'd0);
        repeat (4) advance_time();
        // Rewrite a finished slot: it runs again
        load_slot(4'd1, 8'hC3, 16'd3, 16'd1, 8'd9);
        advance_time();
        advance_time();

        // Random part: loads land among ticks, so preemption and ties come often
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == CHOKE_AT)
                choke_req = 1'b1;
            if (n == DRAIN_AT)
            begin
                cmd.valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            if ((n >= CHOKE_AT && n < CHOKE_AT + CHOKE_ITEMS) || $urandom_range(0, 99) >= 35)
                advance_time();
            else
            begin
                // Arrival mostly at or just after the current time, sometimes in
                // the past, sometimes anywhere
                roll = $urandom_range(0, 15);
                if (roll == 0)
                    arr = TIME_W'($urandom_range(0, 16'hFFFF));
                else if (roll < 4)
                    arr = (issued_time > 8) ? TIME_W'(issued_time - $urandom_range(0, 8))
                                            : '0;
                else
                    arr = TIME_W'(issued_time + $urandom_range(0, 4));
                // Short bursts keep completions frequent
                roll = $urandom_range(0, 24);
                if (roll == 0)
                    burst = '0;
                else if (roll == 1)
                    burst = TIME_W'($urandom_range(0, 16'hFFFF));
                else
                    burst = TIME_W'($urandom_range(1, 6));
                // Narrow priority range for ties
                prio = ($urandom_range(0, 7) == 0) ? PRIO_W'($urandom_range(0, 255))
                                                   : PRIO_W'($urandom_range(0, 3));
                load_slot(SLOT_W'($urandom_range(0, SLOTS - 1)),
                          ID_W'($urandom_range(0, 255)), arr, burst, prio);
            end
        end

        // Quiet tail with no idling. Fill the table with quick work, run it out,
        // then a few idle ticks with everything done.
        quiet = 1'b1;
        for (n = 0; n < SLOTS; n++)
            load_slot(SLOT_W'(n), ID_W'(n), 16'd0, 16'd1, 8'hFF);
        repeat (SLOTS + 4) advance_time();

        // Drain, then let the failure count settle
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
